FILE: src/psc_pkg.sv
`default_nettype none

package psc_pkg;

  typedef enum logic [2:0] {
    KIND_COPY  = 3'd0,
    KIND_SKIP  = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_FLUSH = 3'd3,
    KIND_DONE  = 3'd4,
    KIND_ERROR = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_BADCMD   = 4'd1,
    ERR_EMPTY    = 4'd2,
    ERR_LZERO    = 4'd3,
    ERR_CR       = 4'd4,
    ERR_NONDIGIT = 4'd5,
    ERR_BADFLUSH = 4'd6,
    ERR_EARLY    = 4'd7,
    ERR_OVERFLOW = 4'd8
  } err_e;

  localparam logic [7:0] ChCopy   = 8'h63;  // 'c'
  localparam logic [7:0] ChSkip   = 8'h73;  // 's'
  localparam logic [7:0] ChInject = 8'h69;  // 'i'
  localparam logic [7:0] ChFlush  = 8'h66;  // 'f'
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam int unsigned OutLenWidth = 32;

  // One queue entry: a result, optionally followed by a done result.
  typedef struct packed {
    kind_e                   kind;
    logic [OutLenWidth-1:0]  length;
    logic [7:0]              data_byte;
    err_e                    error_code;
    logic                    then_done;
  } res_t;

endpackage

`default_nettype wire

FILE: src/patch_stream_command_parser.sv
// Patch command stream parser.
// Input side is a queue write port: an item (cmd_i, patch_byte_i) is taken at a
// rising edge with push high and full low. cmd_i high marks end of patch.
// Result side is a queue read port: while empty is low the oldest result sits on
// kind_o, length_o, data_byte_o, error_code_o and last_o, and pop takes it.
// The parser front end handles one item per cycle while full is low and writes
// at most one entry per item into a four-entry queue; the back end expands an
// entry that carries a trailing done into two results. A result passes through
// the queue and then the output register before it shows on the output ports.
// Sustained rate is one item per cycle while full is low; only the final item
// of a patch may give two results. When the receiver stalls, the queue fills
// and full rises after four pending entries plus the one in the output register.
// Reset clears the parser to expect a command letter, empties the queue and the
// output register. After a done or an error result the block drops all further
// items until reset.

`default_nettype none

module patch_stream_command_parser
  import psc_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  patch_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       kind_o,
  output logic [31:0]      length_o,
  output logic [7:0]       data_byte_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t head;
  logic q_empty;
  logic q_pop;

  assign accept = push && !full;

  psc_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .cmd_i        (cmd_i),
    .patch_byte_i (patch_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  psc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .rd_i      (q_pop),
    .rd_data_o (head),
    .empty_o   (q_empty),
    .full_o    (full)
  );

  psc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .length_o     (length_o),
    .data_byte_o  (data_byte_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

FILE: src/psc_front.sv
`default_nettype none

module psc_front
  import psc_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic       cmd_i,
  input  wire logic [7:0] patch_byte_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_LEN   = 3'd1,
    PH_INJ   = 3'd2,
    PH_OPTNL = 3'd3,
    PH_FLUSH = 3'd4
  } phase_e;

  localparam logic [1:0] PendCopy   = 2'd0;
  localparam logic [1:0] PendSkip   = 2'd1;
  localparam logic [1:0] PendInject = 2'd2;

  phase_e                  phase_q, phase_d;
  logic [1:0]              pend_q, pend_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic                    halted_q, halted_d;

  logic                    is_digit;
  logic [3:0]              digit;
  logic [LENGTH_WIDTH+3:0] acc_ext;
  logic [LENGTH_WIDTH+3:0] acc_next;
  logic                    ovf;
  logic                    acc_zero;
  logic [LENGTH_WIDTH-1:0] rem_dec;
  kind_e                   cs_kind;

  // Decode of a byte taken as a command letter.
  logic                    let_ok;
  phase_e                  let_phase;
  logic [1:0]              let_pend;

  assign is_digit = patch_byte_i inside {[ChZero:ChNine]};
  assign digit    = 4'(patch_byte_i - ChZero);
  assign acc_ext  = {4'b0, acc_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (LENGTH_WIDTH+4)'(digit);
  assign ovf      = |acc_next[LENGTH_WIDTH+3:LENGTH_WIDTH];
  assign acc_zero = (acc_q == '0);
  assign rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign cs_kind  = (pend_q == PendSkip) ? KIND_SKIP : KIND_COPY;

  always_comb begin
    let_ok    = 1'b1;
    let_phase = PH_LEN;
    let_pend  = pend_q;
    case (patch_byte_i)
      ChCopy:   let_pend = PendCopy;
      ChSkip:   let_pend = PendSkip;
      ChInject: let_pend = PendInject;
      ChFlush:  let_phase = PH_FLUSH;
      default:  let_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DONE, length: '0, data_byte: '0,
                    error_code: ERR_NONE, then_done: 1'b0};

    if (valid_i && !halted_q) begin
      case (phase_q)
        PH_LEN: begin
          if (cmd_i) begin
            res_valid_o = 1'b1;
            halted_d    = 1'b1;
            if (acc_zero || pend_q >= PendInject) begin
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_EARLY;
            end else begin
              res_o.kind      = cs_kind;
              res_o.length    = OutLenWidth'(acc_q);
              res_o.then_done = 1'b1;
            end
          end else if (patch_byte_i == ChLf) begin
            if (acc_zero) begin
              res_valid_o      = 1'b1;
              halted_d         = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_EMPTY;
            end else if (pend_q >= PendInject) begin
              rem_d   = acc_q;
              phase_d = PH_INJ;
            end else begin
              res_valid_o  = 1'b1;
              res_o.kind   = cs_kind;
              res_o.length = OutLenWidth'(acc_q);
              phase_d      = PH_CMD;
            end
          end else if (patch_byte_i == ChCr) begin
            res_valid_o      = 1'b1;
            halted_d         = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_CR;
          end else if (is_digit) begin
            if (acc_zero && digit == 4'd0) begin
              res_valid_o      = 1'b1;
              halted_d         = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_LZERO;
            end else if (ovf) begin
              res_valid_o      = 1'b1;
              halted_d         = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_OVERFLOW;
            end else begin
              acc_d = acc_next[LENGTH_WIDTH-1:0];
            end
          end else begin
            res_valid_o      = 1'b1;
            halted_d         = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NONDIGIT;
          end
        end
        PH_INJ: begin
          res_valid_o = 1'b1;
          if (cmd_i) begin
            halted_d         = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_EARLY;
          end else begin
            res_o.kind      = KIND_DATA;
            res_o.data_byte = patch_byte_i;
            rem_d           = rem_dec;
            if (rem_dec == '0) begin
              phase_d = PH_OPTNL;
            end
          end
        end
        PH_FLUSH: begin
          res_valid_o = 1'b1;
          if (cmd_i) begin
            res_o.kind      = KIND_FLUSH;
            res_o.then_done = 1'b1;
            halted_d        = 1'b1;
          end else if (patch_byte_i == ChLf) begin
            res_o.kind = KIND_FLUSH;
            phase_d    = PH_CMD;
          end else begin
            halted_d         = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_BADFLUSH;
          end
        end
        default: begin
          // Command boundary; after inject data a single newline is dropped.
          if (cmd_i) begin
            res_valid_o = 1'b1;
            halted_d    = 1'b1;
            res_o.kind  = KIND_DONE;
          end else if (phase_q == PH_OPTNL && patch_byte_i == ChLf) begin
            phase_d = PH_CMD;
          end else begin
            acc_d = '0;
            if (let_ok) begin
              phase_d = let_phase;
              pend_d  = let_pend;
            end else begin
              res_valid_o      = 1'b1;
              halted_d         = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_BADCMD;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CMD;
      pend_q   <= PendCopy;
      acc_q    <= '0;
      rem_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/psc_queue.sv
`default_nettype none

module psc_queue
  import psc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire res_t wr_data_i,
  input  wire logic rd_i,
  output res_t      rd_data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned Depth  = 4;
  localparam int unsigned PtrW   = $clog2(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_wr, do_rd;

  assign empty_o   = (cnt_q == '0);
  assign full_o    = (cnt_q == (PtrW+1)'(Depth));
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/psc_back.sv
`default_nettype none

module psc_back
  import psc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire res_t        head_i,
  input  wire logic        q_empty_i,
  output logic             q_pop_o,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       kind_o,
  output logic [31:0]      length_o,
  output logic [7:0]       data_byte_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  logic        out_valid_q;
  logic        done_pend_q;
  logic        load;
  kind_e       kind_q;
  logic [31:0] length_q;
  logic [7:0]  data_q;
  err_e        err_q;
  logic        last_q;

  assign load    = !out_valid_q || pop;
  assign q_pop_o = load && !done_pend_q && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_pend_q <= 1'b0;
    end else if (load) begin
      if (done_pend_q) begin
        out_valid_q <= 1'b1;
        done_pend_q <= 1'b0;
      end else if (!q_empty_i) begin
        out_valid_q <= 1'b1;
        done_pend_q <= head_i.then_done;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A result carrying a trailing done is shown first, then the done itself.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (done_pend_q) begin
        kind_q   <= KIND_DONE;
        length_q <= '0;
        data_q   <= '0;
        err_q    <= ERR_NONE;
        last_q   <= 1'b1;
      end else if (!q_empty_i) begin
        kind_q   <= head_i.kind;
        length_q <= head_i.length;
        data_q   <= head_i.data_byte;
        err_q    <= head_i.error_code;
        last_q   <= !head_i.then_done;
      end
    end
  end

  assign empty        = !out_valid_q;
  assign kind_o       = kind_q;
  assign length_o     = length_q;
  assign data_byte_o  = data_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
